FILE: rtl/mmq_pkg.sv
package mmq_pkg;

  // defaults for the top-level parameters
  localparam int MAX_SAMPLES_DEF  = 64;
  localparam int SAMPLE_WIDTH_DEF = 32;

  // fixed field widths
  localparam int ZONE_W  = 6;
  localparam int LEVEL_W = 16;
  localparam int EXP_W   = 5;
  // quotient holds up to 2^16 before the clamp
  localparam int QUOT_W  = LEVEL_W + 1;

  localparam logic [EXP_W-1:0] EXP_MIN   = EXP_W'(1);
  localparam logic [EXP_W-1:0] EXP_MAX   = EXP_W'(16);
  localparam logic [EXP_W-1:0] EXP_RESET = EXP_W'(4);

endpackage

FILE: rtl/mmq_store.sv
module mmq_store #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/mmq_div.sv
// Restoring divider, one quotient bit per cycle: floor(d * 2^e / r), d <= r,
// clamped to 2^e - 1.
module mmq_div #(
  parameter int WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [WIDTH-1:0]             dividend,
  input  logic [WIDTH-1:0]             divisor,
  input  logic [mmq_pkg::EXP_W-1:0]    exp_eff,
  output logic                         done,
  output logic [mmq_pkg::LEVEL_W-1:0]  level
);
  import mmq_pkg::*;

  logic [WIDTH-1:0]  rem;
  logic [QUOT_W-1:0] quot;
  logic [EXP_W-1:0]  cnt;
  logic              busy;
  logic [WIDTH:0]    rem2;
  logic              ge;
  logic              ge0;
  logic [QUOT_W-1:0] nmax;

  always_comb begin
    rem2 = {rem, 1'b0};
    ge   = rem2 >= {1'b0, divisor};
    ge0  = dividend >= divisor;
    nmax = (QUOT_W'(1) << exp_eff) - QUOT_W'(1);
    level = (quot > nmax) ? nmax[LEVEL_W-1:0] : quot[LEVEL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= exp_eff;
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - EXP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= QUOT_W'(ge0);
      rem  <= ge0 ? dividend - divisor : dividend;
    end else if (busy && cnt != '0) begin
      quot <= {quot[QUOT_W-2:0], ge};
      rem  <= ge ? WIDTH'(rem2 - {1'b0, divisor}) : rem2[WIDTH-1:0];
    end
  end

endmodule

FILE: rtl/mmq_mid.sv
// Shift-add multiplier, LSB first: floor(r * (2k+1) / 2^(e+1)).
// 2k+1 has at most e+1 bits, so after e+1 steps the high part is the result.
module mmq_mid #(
  parameter int WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [WIDTH-1:0]            span,
  input  logic [mmq_pkg::LEVEL_W-1:0] level,
  input  logic [mmq_pkg::EXP_W-1:0]   exp_eff,
  output logic                        done,
  output logic [WIDTH-1:0]            offset
);
  import mmq_pkg::*;

  logic [QUOT_W-1:0] odd;
  logic [EXP_W-1:0]  cnt;
  logic              busy;
  logic [WIDTH:0]    sum;

  assign sum = {1'b0, offset} + (odd[0] ? {1'b0, span} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= exp_eff + EXP_W'(1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - EXP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      odd    <= {level, 1'b1};
      offset <= '0;
    end else if (busy && cnt != '0) begin
      odd    <= odd >> 1;
      offset <= sum[WIDTH:1];
    end
  end

endmodule

FILE: rtl/minmax_uniform_level_quantizer.sv
// Load: one sample item per cycle, min/max tracked on the fly; input stalls while emitting.
// Emission, per result in order: read, setup, start, the serial divider, the mid-value
//   multiplier and output (e = clamped exponent, 1..16).
// Zero range skips divider and multiplier. Output stalls hold the sequencer in the output state.
// Reset (rst, synchronous): empty set, min = max = 0, exponent = 4.
module minmax_uniform_level_quantizer #(
  parameter int MAX_SAMPLES  = mmq_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_WIDTH = mmq_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                level_exponent_we,
  input  logic [mmq_pkg::EXP_W-1:0]           level_exponent,
  // sample channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_value,
  input  logic                                last_sample,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mmq_pkg::ZONE_W-1:0]          zone_index,
  output logic signed [SAMPLE_WIDTH-1:0]      echoed_value,
  output logic [mmq_pkg::LEVEL_W-1:0]         level_index,
  output logic signed [SAMPLE_WIDTH-1:0]      level_value,
  output logic                                last_result
);
  import mmq_pkg::*;

  localparam int W  = SAMPLE_WIDTH;
  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  // sequencer states
  localparam logic [2:0] ST_LOAD  = 3'd0;  // taking samples
  localparam logic [2:0] ST_READ  = 3'd1;  // store read issued
  localparam logic [2:0] ST_SETUP = 3'd2;  // read data back, form x - min
  localparam logic [2:0] ST_START = 3'd3;  // kick divider or take zero-range path
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_MID   = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;  // wait for a free output register

  logic [2:0]          state;
  logic [EXP_W-1:0]    exponent;   // config register
  logic [EXP_W-1:0]    exp_run;    // clamped exponent for the current run
  logic [EXP_W-1:0]    exp_eff;
  logic [CW-1:0]       count;
  logic [AW-1:0]       idx;
  logic signed [W-1:0] run_min;
  logic signed [W-1:0] run_max;
  logic [W-1:0]        span;
  logic signed [W-1:0] cur_val;
  logic [W-1:0]        diff;
  logic [LEVEL_W-1:0]  cur_level;
  logic signed [W-1:0] cur_lv;

  logic                in_take;
  logic                store_we;
  logic                out_free;
  logic                is_last;
  logic [W-1:0]        rd_data;
  logic                div_start;
  logic                div_done;
  logic [LEVEL_W-1:0]  div_level;
  logic                mid_start;
  logic                mid_done;
  logic [W-1:0]        mid_offset;

  assign in_stall  = (state != ST_LOAD);
  assign in_take   = in_valid && !in_stall;
  assign store_we  = in_take && (count < CW'(MAX_SAMPLES));
  assign out_free  = !out_valid || !out_stall;
  assign is_last   = (CW'(idx) + CW'(1)) == count;
  assign div_start = (state == ST_START) && (span != '0);
  assign mid_start = (state == ST_DIV) && div_done;

  always_comb begin
    if (exponent < EXP_MIN) begin
      exp_eff = EXP_MIN;
    end else if (exponent > EXP_MAX) begin
      exp_eff = EXP_MAX;
    end else begin
      exp_eff = exponent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exponent <= EXP_RESET;
    end else if (level_exponent_we) begin
      exponent <= level_exponent;
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      idx       <= '0;
      run_min   <= '0;
      run_max   <= '0;
      out_valid <= 1'b0;
      exp_run   <= EXP_RESET;
    end else begin
      // output register: refilled when free, else dropped once taken
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_LOAD: begin
          if (in_take) begin
            if (store_we) begin
              // first item of a set seeds both extremes
              if (count == '0) begin
                run_min <= sample_value;
                run_max <= sample_value;
              end else begin
                if (sample_value < run_min) run_min <= sample_value;
                if (sample_value > run_max) run_max <= sample_value;
              end
              count <= count + CW'(1);
            end
            if (last_sample) begin
              exp_run <= exp_eff;
              idx     <= '0;
              state   <= ST_READ;
            end
          end
        end
        ST_READ:  state <= ST_SETUP;
        ST_SETUP: state <= ST_START;
        ST_START: state <= (span != '0) ? ST_DIV : ST_OUT;
        ST_DIV: begin
          if (div_done) state <= ST_MID;
        end
        ST_MID: begin
          if (mid_done) state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            if (is_last) begin
              count <= '0;
              state <= ST_LOAD;
            end else begin
              idx   <= idx + AW'(1);
              state <= ST_READ;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      span <= W'(run_max - run_min);
    end
    if (state == ST_SETUP) begin
      cur_val <= rd_data;
      diff    <= W'(rd_data - run_min);
    end
    if (state == ST_START && span == '0) begin
      // zero range: every sample sits in level 0 at the minimum
      cur_level <= '0;
      cur_lv    <= run_min;
    end
    if (mid_start) begin
      cur_level <= div_level;
    end
    if (state == ST_MID && mid_done) begin
      cur_lv <= W'(run_min + mid_offset);
    end
    if (state == ST_OUT && out_free) begin
      zone_index   <= ZONE_W'(idx);
      echoed_value <= cur_val;
      level_index  <= cur_level;
      level_value  <= cur_lv;
      last_result  <= is_last;
    end
  end

  mmq_store #(
    .DEPTH (MAX_SAMPLES),
    .WIDTH (W)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (count[AW-1:0]),
    .wdata (sample_value),
    .raddr (idx),
    .rdata (rd_data)
  );

  mmq_div #(
    .WIDTH (W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (diff),
    .divisor  (span),
    .exp_eff  (exp_run),
    .done     (div_done),
    .level    (div_level)
  );

  mmq_mid #(
    .WIDTH (W)
  ) u_mid (
    .clk     (clk),
    .rst     (rst),
    .start   (mid_start),
    .span    (span),
    .level   (div_level),
    .exp_eff (exp_run),
    .done    (mid_done),
    .offset  (mid_offset)
  );

endmodule

FILE: test/tb.sv
module tb;
  import mmq_pkg::*;

  localparam int STORE_DEPTH = MAX_SAMPLES_DEF;
  localparam int SAMPLE_W = SAMPLE_WIDTH_DEF;
  // stored items wanted from the random part
  localparam int RANDOM_ITEMS = 350;
  // calm-down time after the last owed result, so the block is idle again
  localparam int SETTLE_CYCLES = 60;
  // long hold-off of the result side, so the block fills and stalls samples
  localparam int HOLD_CYCLES = 300;
  // cycles with no handshake on either side before the run is abandoned
  localparam int WATCHDOG_LIMIT = 4000;

  typedef enum logic {ROW_SAMPLE, ROW_CONFIG} row_kind_t;

  // one directed step; for config rows value carries the exponent
  typedef struct {
    row_kind_t kind;
    logic signed [SAMPLE_W-1:0] value;
    logic last;
    bit typed;
    logic [LEVEL_W-1:0] t_level;
    logic signed [SAMPLE_W-1:0] t_mid;
  } sample_row_t;

  // one quantized result as the block should emit it
  typedef struct {
    logic [ZONE_W-1:0] zone;
    logic signed [SAMPLE_W-1:0] echoed;
    logic [LEVEL_W-1:0] level;
    logic signed [SAMPLE_W-1:0] mid;
    logic last;
  } level_result_t;

  logic clk = 1'b0;
  logic rst;
  logic level_exponent_we;
  logic [EXP_W-1:0] level_exponent;
  logic in_valid;
  logic in_stall;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic last_sample;
  logic out_valid;
  logic out_stall;
  logic [ZONE_W-1:0] zone_index;
  logic signed [SAMPLE_W-1:0] echoed_value;
  logic [LEVEL_W-1:0] level_index;
  logic signed [SAMPLE_W-1:0] level_value;
  logic last_result;

  minmax_uniform_level_quantizer #(
    .MAX_SAMPLES(STORE_DEPTH),
    .SAMPLE_WIDTH(SAMPLE_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .level_exponent_we(level_exponent_we),
    .level_exponent(level_exponent),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample_value(sample_value),
    .last_sample(last_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .zone_index(zone_index),
    .echoed_value(echoed_value),
    .level_index(level_index),
    .level_value(level_value),
    .last_result(last_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shadow copy of the quantizer: sample store, fill count, running
  // min/max of the set and the exponent register.
  // ---------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] sample_store [STORE_DEPTH];
  int fill_count;
  logic signed [SAMPLE_W-1:0] set_lo;
  logic signed [SAMPLE_W-1:0] set_hi;
  logic [EXP_W-1:0] exp_reg;

  level_result_t pending_levels[$];   // results still owed by the block
  int errors = 0;
  int stored_items;                   // items that actually went into the store
  bit quiet;                          // no random idling on either side
  bit hold_request;                   // asks the receiver for one long hold-off

  // Take one accepted sample; on a last mark, queue one result per stored
  // sample. Samples arriving on a full store are dropped, but their last
  // mark still counts.
  function automatic void predict_levels(input logic signed [SAMPLE_W-1:0] x,
                                         input logic is_last);
    int unsigned e;
    longint span, k, top, offs;
    level_result_t r;
    if (fill_count < STORE_DEPTH) begin
      if (fill_count == 0) begin
        set_lo = x;
        set_hi = x;
      end else begin
        if (x < set_lo) set_lo = x;
        if (x > set_hi) set_hi = x;
      end
      sample_store[fill_count] = x;
      fill_count++;
    end
    if (!is_last) return;
    // exponent is clamped to 1..16 when used, not when written
    e = 32'(exp_reg);
    if (exp_reg < EXP_MIN) e = 32'(EXP_MIN);
    if (exp_reg > EXP_MAX) e = 32'(EXP_MAX);
    top = (longint'(1) << e) - 1;
    span = longint'(set_hi) - longint'(set_lo);
    for (int i = 0; i < fill_count; i++) begin
      r.zone = ZONE_W'(i);
      r.echoed = sample_store[i];
      // zero span: level 0, mid value is the min itself
      r.level = '0;
      r.mid = set_lo;
      if (span != 0) begin
        k = ((longint'(sample_store[i]) - longint'(set_lo)) << e) / span;
        if (k > top) k = top;   // the max lands on level N, pulled back to N-1
        offs = (span * (2 * k + 1)) >> (e + 1);
        r.level = LEVEL_W'(k);
        r.mid = SAMPLE_W'(longint'(set_lo) + offs);
      end
      r.last = (i == fill_count - 1);
      pending_levels.push_back(r);
    end
    fill_count = 0;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Result checker: every accepted result against the oldest expectation.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    level_result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_levels.size() == 0) begin
        $display("%0t: unexpected result zone %h value %h level %h mid %h last %b",
                 $time, zone_index, echoed_value, level_index, level_value,
                 last_result);
        errors++;
      end else begin
        want = pending_levels.pop_front();
        check_field("zone_index", 32'(want.zone), 32'(zone_index));
        check_field("echoed_value", want.echoed, echoed_value);
        check_field("level_index", 32'(want.level), 32'(level_index));
        check_field("level_value", want.mid, level_value);
        check_field("last_result", 32'(want.last), 32'(last_result));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: any handshake on either side restarts the count.
  // ---------------------------------------------------------------------
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Result side: random stall bursts, one long hold-off on request, steady
  // acceptance once the run goes quiet.
  // ---------------------------------------------------------------------
  initial begin : receiver
    int gap;
    bit hold_done;
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        gap = $urandom_range(1, 8);
        repeat (gap) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sample side. Tasks start and end at a falling edge.
  // ---------------------------------------------------------------------
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] v, input logic l);
    in_valid <= 1'b1;
    sample_value <= v;
    last_sample <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (fill_count < STORE_DEPTH) stored_items++;
    predict_levels(v, l);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(negedge clk);
    end
  endtask

  // wait until every owed result is out and the block has gone idle
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_exponent(input logic [EXP_W-1:0] v);
    level_exponent_we <= 1'b1;
    level_exponent <= v;
    exp_reg = v;
    @(negedge clk);
    level_exponent_we <= 1'b0;
  endtask

  // Directed part. Single-sample sets have zero span, so the result is
  // level 0 with the sample as mid value; those rows carry it typed in.
  sample_row_t directed_rows [23];

  initial begin : stimulus
    int len, mode, set_no;
    logic signed [SAMPLE_W-1:0] base, v;
    logic [EXP_W-1:0] new_exp;

    rst = 1'b1;
    in_valid = 1'b0;
    sample_value = '0;
    last_sample = 1'b0;
    level_exponent_we = 1'b0;
    level_exponent = '0;
    stored_items = 0;
    quiet = 1'b0;
    hold_request = 1'b0;
    fill_count = 0;
    set_lo = '0;
    set_hi = '0;
    exp_reg = EXP_RESET;

    directed_rows = '{
      // lone samples at both extremes and at zero, under the reset exponent
      '{ROW_SAMPLE, 32'sh7FFFFFFF, 1'b1, 1'b1, 16'd0, 32'sh7FFFFFFF},
      '{ROW_SAMPLE, 32'sh80000000, 1'b1, 1'b1, 16'd0, 32'sh80000000},
      '{ROW_SAMPLE, 32'sh00000000, 1'b1, 1'b1, 16'd0, 32'sh00000000},
      // widest possible span
      '{ROW_SAMPLE, 32'sh80000000, 1'b0, 1'b0, 16'd0, 32'sh0},
      '{ROW_SAMPLE, 32'sh7FFFFFFF, 1'b1, 1'b0, 16'd0, 32'sh0},
      // several equal samples: zero span
      '{ROW_SAMPLE, 32'sd5, 1'b0, 1'b0, 16'd0, 32'sh0},
      '{ROW_SAMPLE, 32'sd5, 1'b0, 1'b0, 16'd0, 32'sh0},
      '{ROW_SAMPLE, 32'sd5, 1'b1, 1'b0, 16'd0, 32'sh0},
      // exponent zero is used as one
      '{ROW_CONFIG, 32'sd0, 1'b0, 1'b0, 16'd0, 32'sh0},
      '{ROW_SAMPLE, -32'sd100, 1'b0, 1'b0, 16'd0, 32'sh0},
      '{ROW_SAMPLE, 32'sd100, 1'b0, 1'b0, 16'd0, 32'sh0},
      '{ROW_SAMPLE, 32'sd37, 1'b0, 1'b0, 16'd0, 32'sh0},
      '{ROW_SAMPLE, -32'sd1, 1'b1, 1'b0, 16'd0, 32'sh0},
      // all ones saturates to sixteen
      '{ROW_CONFIG, 32'sd31, 1'b0, 1'b0, 16'd0, 32'sh0},
      '{ROW_SAMPLE, 32'sh80000000, 1'b0, 1'b0, 16'd0, 32'sh0},
      '{ROW_SAMPLE, 32'sh7FFFFFFF, 1'b0, 1'b0, 16'd0, 32'sh0},
      '{ROW_SAMPLE, 32'sh12345678, 1'b1, 1'b0, 16'd0, 32'sh0},
      '{ROW_CONFIG, 32'sd16, 1'b0, 1'b0, 16'd0, 32'sh0},
      '{ROW_SAMPLE, 32'sd0, 1'b0, 1'b0, 16'd0, 32'sh0},
      '{ROW_SAMPLE, 32'sd65535, 1'b1, 1'b0, 16'd0, 32'sh0},
      // two levels over a span of one
      '{ROW_CONFIG, 32'sd1, 1'b0, 1'b0, 16'd0, 32'sh0},
      '{ROW_SAMPLE, 32'sh7FFFFFFE, 1'b0, 1'b0, 16'd0, 32'sh0},
      '{ROW_SAMPLE, 32'sh7FFFFFFF, 1'b1, 1'b0, 16'd0, 32'sh0}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[n]) begin
      if (directed_rows[n].kind == ROW_CONFIG) begin
        settle();
        write_exponent(EXP_W'(directed_rows[n].value));
      end else begin
        send_sample(directed_rows[n].value, directed_rows[n].last);
        if (directed_rows[n].typed)
          pending_levels[pending_levels.size() - 1] = '{ZONE_W'(0),
              directed_rows[n].value, directed_rows[n].t_level,
              directed_rows[n].t_mid, 1'b1};
        sender_gap();
      end
    end
    settle();
    write_exponent(EXP_W'(17));

    // Random sets: mostly short, now and then long enough to overflow the
    // store. The exponent changes between sets while the block is idle.
    stored_items = 0;
    set_no = 0;
    while (stored_items < RANDOM_ITEMS) begin
      if (stored_items >= RANDOM_ITEMS - 50) quiet = 1'b1;
      if (set_no > 0 && $urandom_range(0, 3) == 0) begin
        settle();
        case ($urandom_range(0, 5))
          0: new_exp = '0;
          1: new_exp = EXP_MIN;
          2: new_exp = EXP_MAX;
          3: new_exp = '1;
          default: new_exp = EXP_W'($urandom_range(0, 31));
        endcase
        write_exponent(new_exp);
      end
      case ($urandom_range(0, 9))
        0: len = $urandom_range(60, 70);
        1: len = 1;
        default: len = $urandom_range(2, 12);
      endcase
      // long hold-off while a fair-sized set keeps coming
      if (set_no == 3) begin
        hold_request = 1'b1;
        len = 24;
      end
      mode = $urandom_range(0, 3);
      base = $urandom;
      for (int j = 0; j < len; j++) begin
        case (mode)
          0: v = $urandom;
          1: v = base + SAMPLE_W'($urandom_range(0, 255));
          2: v = base;
          default:
            case ($urandom_range(0, 4))
              0: v = 32'sh80000000;
              1: v = 32'sh7FFFFFFF;
              2: v = '0;
              3: v = '1;
              default: v = $urandom;
            endcase
        endcase
        send_sample(v, j == len - 1);
        sender_gap();
      end
      set_no++;
    end

    settle();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
